@@ rtl/core/sfp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types, codes and character constants of the frame parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

  localparam int MaxHeadersDefault = 16;
  localparam int LengthBitsDefault = 32;
  localparam int QueueDepth        = 4;

  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic [3:0]  KeyLen    = 4'd14;
  localparam logic [31:0] SatOctets = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    PH_SKIP       = 3'd0,
    PH_CMD        = 3'd1,
    PH_HDR        = 3'd2,
    PH_BODY_SIZED = 3'd3,
    PH_BODY_OPEN  = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ROLE_SKIP      = 3'd0,
    ROLE_CMD       = 3'd1,
    ROLE_HDR_NAME  = 3'd2,
    ROLE_COLON     = 3'd3,
    ROLE_HDR_VALUE = 3'd4,
    ROLE_LINE_END  = 3'd5,
    ROLE_BODY      = 3'd6,
    ROLE_NUL       = 3'd7
  } role_e;

  typedef enum logic [2:0] {
    ST_BUSY          = 3'd0,
    ST_OK            = 3'd1,
    ST_NO_COLON      = 3'd2,
    ST_BAD_LENGTH    = 3'd3,
    ST_NUL_MISPLACED = 3'd4,
    ST_INCOMPLETE    = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  byte_role;
    logic [7:0]  byte_value;
    logic [4:0]  header_slot;
    logic        frame_done;
    logic [2:0]  status;
    logic [31:0] body_length;
    logic [4:0]  header_total;
    logic [31:0] consumed_octets;
    logic        last_of_run;
  } out_item_t;

  // up to two results produced by one byte
  typedef struct packed {
    logic [1:0]          count;
    out_item_t [1:0]     item;
  } res_pair_t;

  // "content-length", one character per match position
  function automatic logic [7:0] key_char(input logic [3:0] pos);
    logic [7:0] ch;
    unique case (pos)
      4'd0:    ch = 8'h63;
      4'd1:    ch = 8'h6F;
      4'd2:    ch = 8'h6E;
      4'd3:    ch = 8'h74;
      4'd4:    ch = 8'h65;
      4'd5:    ch = 8'h6E;
      4'd6:    ch = 8'h74;
      4'd7:    ch = 8'h2D;
      4'd8:    ch = 8'h6C;
      4'd9:    ch = 8'h65;
      4'd10:   ch = 8'h6E;
      4'd11:   ch = 8'h67;
      4'd12:   ch = 8'h74;
      4'd13:   ch = 8'h68;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/core/sfp_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface sfp_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/sfp_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_in_stage
// Input register; holds one byte until the parse engine takes it.
// ----------------------------------------------------------------------------
module sfp_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  sfp_stream_if.sink        in_i,
  input  logic              take_i,
  output logic              valid_o,
  output sfp_pkg::in_item_t item_o
);
  import sfp_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  assign in_i.ready = !valid_q || take_i;
  assign load       = in_i.valid && in_i.ready;
  assign valid_d    = load ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_i.payload;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ rtl/core/sfp_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_engine
// Grammar state and per-byte tagging; emits up to two results per byte.
// ----------------------------------------------------------------------------
module sfp_engine #(
  parameter int MAX_HEADERS = sfp_pkg::MaxHeadersDefault,
  parameter int LENGTH_BITS = sfp_pkg::LengthBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  sfp_pkg::in_item_t  item_i,
  input  logic               space_i,
  output logic               take_o,
  output sfp_pkg::res_pair_t push_o
);
  import sfp_pkg::*;

  localparam int KW = $clog2(MAX_HEADERS + 1);
  localparam int LW = LENGTH_BITS + 32;
  localparam logic [LENGTH_BITS-1:0] LenMax   = '1;
  localparam logic [LENGTH_BITS-1:0] LenLimit =
    (LenMax - LENGTH_BITS'(9)) / LENGTH_BITS'(10);
  localparam logic [KW-1:0] MaxKept = KW'(MAX_HEADERS);

  typedef struct packed {
    phase_e                 phase;
    logic                   held_cr;
    logic                   line_content;
    logic                   colon_found;
    logic [KW-1:0]          kept_cnt;
    logic [3:0]             match_pos;
    logic                   mismatch;
    logic                   len_seen;
    logic [LENGTH_BITS-1:0] len_acc;
    logic                   digits_bad;
    logic [LENGTH_BITS-1:0] body_cnt;
    logic [31:0]            frame_octets;
    logic                   len_active;
    logic                   digit_seen;
  } eng_state_t;

  typedef struct packed {
    eng_state_t s;
    role_e      role;
  } content_t;

  typedef struct packed {
    eng_state_t s;
    status_e    close;
  } line_end_t;

  typedef struct packed {
    eng_state_t s;
    res_pair_t  res;
  } step_t;

  function automatic eng_state_t reset_state();
    eng_state_t s;
    s              = '0;
    s.phase        = PH_SKIP;
    return s;
  endfunction

  function automatic eng_state_t clear_line(input eng_state_t cur);
    eng_state_t s;
    s              = cur;
    s.line_content = 1'b0;
    s.colon_found  = 1'b0;
    s.match_pos    = 4'd0;
    s.mismatch     = 1'b0;
    s.len_active   = 1'b0;
    s.digit_seen   = 1'b0;
    s.digits_bad   = 1'b0;
    return s;
  endfunction

  function automatic logic [31:0] clip_len(input logic [LENGTH_BITS-1:0] v);
    logic [LW-1:0] wide;
    wide = LW'(v);
    if (wide > LW'(SatOctets)) begin
      return SatOctets;
    end
    return 32'(v);
  endfunction

  function automatic out_item_t mk_result(input eng_state_t s, input role_e role,
                                          input logic [7:0] v);
    out_item_t r;
    r                 = '0;
    r.byte_role       = role;
    r.byte_value      = v;
    r.header_slot     = 5'(s.kept_cnt);
    r.frame_done      = 1'b0;
    r.status          = ST_BUSY;
    r.body_length     = clip_len(s.body_cnt);
    r.header_total    = 5'(s.kept_cnt);
    r.consumed_octets = s.frame_octets;
    r.last_of_run     = 1'b0;
    return r;
  endfunction

  function automatic res_pair_t push(input res_pair_t cur, input out_item_t r);
    res_pair_t p;
    p = cur;
    if (p.count == 2'd0) begin
      p.item[0] = r;
    end else if (p.count == 2'd1) begin
      p.item[1] = r;
    end
    if (p.count != 2'd2) begin
      p.count = p.count + 2'd1;
    end
    return p;
  endfunction

  function automatic role_e line_role(input eng_state_t s);
    if (s.phase == PH_CMD) begin
      return ROLE_CMD;
    end
    return s.colon_found ? ROLE_HDR_VALUE : ROLE_HDR_NAME;
  endfunction

  function automatic content_t content(input eng_state_t cur, input logic [7:0] b);
    content_t c;
    c.s              = cur;
    c.role           = ROLE_CMD;
    c.s.line_content = 1'b1;
    if (cur.phase != PH_CMD) begin
      if (!cur.colon_found) begin
        if (b == CharColon) begin
          c.s.colon_found = 1'b1;
          c.s.len_active  = !cur.mismatch && cur.match_pos == KeyLen &&
                            cur.kept_cnt < MaxKept && !cur.len_seen;
          if (c.s.len_active) begin
            c.s.len_acc = '0;
          end
          c.s.digits_bad  = 1'b0;
          c.s.digit_seen  = 1'b0;
          c.role          = ROLE_COLON;
        end else begin
          if (!cur.mismatch) begin
            if (cur.match_pos < KeyLen && b == key_char(cur.match_pos)) begin
              c.s.match_pos = cur.match_pos + 4'd1;
            end else begin
              c.s.mismatch = 1'b1;
            end
          end
          c.role = ROLE_HDR_NAME;
        end
      end else begin
        if (cur.len_active && !cur.digits_bad) begin
          if (b >= CharZero && b <= CharNine) begin
            // conservative overflow test before the multiply-add
            if (cur.len_acc > LenLimit) begin
              c.s.digits_bad = 1'b1;
            end else begin
              c.s.len_acc    = (cur.len_acc << 3) + (cur.len_acc << 1) +
                               LENGTH_BITS'(b[3:0]);
              c.s.digit_seen = 1'b1;
            end
          end else begin
            c.s.digits_bad = 1'b1;
          end
        end
        c.role = ROLE_HDR_VALUE;
      end
    end
    return c;
  endfunction

  function automatic line_end_t end_line(input eng_state_t cur);
    line_end_t le;
    le.s     = cur;
    le.close = ST_BUSY;
    if (cur.phase == PH_CMD) begin
      le.s.phase = PH_HDR;
      le.s       = clear_line(le.s);
    end else if (!cur.line_content) begin
      // blank line closes the header block
      le.s.phase    = cur.len_seen ? PH_BODY_SIZED : PH_BODY_OPEN;
      le.s.body_cnt = '0;
      le.s          = clear_line(le.s);
    end else if (!cur.colon_found) begin
      le.close = ST_NO_COLON;
    end else if (cur.len_active && (cur.digits_bad || !cur.digit_seen)) begin
      le.close = ST_BAD_LENGTH;
    end else begin
      if (cur.len_active) begin
        le.s.len_seen = 1'b1;
      end
      if (cur.kept_cnt < MaxKept) begin
        le.s.kept_cnt = cur.kept_cnt + KW'(1);
      end
      le.s = clear_line(le.s);
    end
    return le;
  endfunction

  function automatic step_t do_step(input eng_state_t cur, input in_item_t it);
    step_t      st;
    eng_state_t s;
    res_pair_t  p;
    content_t   c;
    line_end_t  le;
    status_e    close;
    logic [7:0] b;
    logic       idx;
    s     = cur;
    p     = '0;
    close = ST_BUSY;
    b     = it.data_byte;
    if (s.frame_octets != SatOctets) begin
      s.frame_octets = s.frame_octets + 32'd1;
    end
    if (s.phase == PH_SKIP) begin
      if (b == CharCr || b == CharLf) begin
        p = push(p, mk_result(s, ROLE_SKIP, b));
      end else begin
        s.phase = PH_CMD;
      end
    end
    if (s.phase == PH_CMD || s.phase == PH_HDR) begin
      if (s.held_cr) begin
        s.held_cr = 1'b0;
        if (b == CharLf) begin
          // trimmed cr, then the lf
          p     = push(p, mk_result(s, ROLE_LINE_END, CharCr));
          p     = push(p, mk_result(s, ROLE_LINE_END, CharLf));
          le    = end_line(s);
          s     = le.s;
          close = le.close;
        end else begin
          c = content(s, CharCr);
          s = c.s;
          p = push(p, mk_result(s, c.role, CharCr));
          if (b == CharCr) begin
            s.held_cr = 1'b1;
          end else begin
            c = content(s, b);
            s = c.s;
            p = push(p, mk_result(s, c.role, b));
          end
        end
      end else if (b == CharLf) begin
        p     = push(p, mk_result(s, ROLE_LINE_END, CharLf));
        le    = end_line(s);
        s     = le.s;
        close = le.close;
      end else if (b == CharCr) begin
        s.held_cr = 1'b1;
      end else begin
        c = content(s, b);
        s = c.s;
        p = push(p, mk_result(s, c.role, b));
      end
    end else if (s.phase == PH_BODY_SIZED) begin
      if (s.body_cnt < s.len_acc) begin
        s.body_cnt = s.body_cnt + LENGTH_BITS'(1);
        p          = push(p, mk_result(s, ROLE_BODY, b));
      end else if (b == CharNul) begin
        p     = push(p, mk_result(s, ROLE_NUL, b));
        close = ST_OK;
      end else begin
        p     = push(p, mk_result(s, ROLE_SKIP, b));
        close = ST_NUL_MISPLACED;
      end
    end else if (s.phase == PH_BODY_OPEN) begin
      if (b == CharNul) begin
        p     = push(p, mk_result(s, ROLE_NUL, b));
        close = ST_OK;
      end else begin
        if (s.body_cnt != LenMax) begin
          s.body_cnt = s.body_cnt + LENGTH_BITS'(1);
        end
        p = push(p, mk_result(s, ROLE_BODY, b));
      end
    end
    if (close == ST_BUSY && it.end_of_buffer) begin
      // buffer ran dry mid-frame: release a held cr as content first
      if (s.held_cr) begin
        s.held_cr = 1'b0;
        p         = push(p, mk_result(s, line_role(s), CharCr));
      end
      close = ST_INCOMPLETE;
    end
    if (p.count != 2'd0) begin
      idx                      = (p.count == 2'd2);
      p.item[idx].last_of_run  = 1'b1;
      if (close != ST_BUSY) begin
        p.item[idx].frame_done      = 1'b1;
        p.item[idx].status          = close;
        p.item[idx].body_length     = (close == ST_OK) ? clip_len(s.body_cnt) : 32'd0;
        p.item[idx].header_total    = 5'(s.kept_cnt);
        p.item[idx].consumed_octets = (close == ST_OK) ? s.frame_octets : 32'd0;
      end
    end
    if (close != ST_BUSY) begin
      s = reset_state();
    end
    st.s   = s;
    st.res = p;
    return st;
  endfunction

  eng_state_t state_q, state_d;
  step_t      step;

  assign take_o = item_valid_i && space_i;
  assign step   = do_step(state_q, item_i);

  always_comb begin
    state_d = state_q;
    if (take_o) begin
      state_d = step.s;
    end
  end

  always_comb begin
    push_o = '0;
    if (take_o) begin
      push_o = step.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= reset_state();
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/sfp_out_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_out_queue
// Small result queue; takes up to two results per cycle, sends one.
// ----------------------------------------------------------------------------
module sfp_out_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfp_pkg::res_pair_t push_i,
  output logic               space_o,
  sfp_stream_if.source       out_o
);
  import sfp_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  out_item_t        entries_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [PtrW-1:0]  wr_next;
  logic             pop;

  assign pop      = out_o.valid && out_o.ready;
  assign wr_next  = wr_ptr_q + PtrW'(1);
  assign wr_ptr_d = wr_ptr_q + PtrW'(push_i.count);
  assign rd_ptr_d = pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
  assign count_d  = count_q + CntW'(push_i.count) - CntW'(pop);

  // room for a full pair before the engine may fire
  assign space_o  = count_q <= CntW'(QueueDepth - 2);

  assign out_o.valid   = count_q != '0;
  assign out_o.payload = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      entries_q[wr_ptr_q] <= push_i.item[0];
    end
    if (push_i.count == 2'd2) begin
      entries_q[wr_next] <= push_i.item[1];
    end
  end

endmodule

@@ rtl/core/stomp_frame_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stomp_frame_parser
// STOMP 1.2 frame parser tagging one received octet per transaction.
// ----------------------------------------------------------------------------
// The parser takes one octet per clock while the result queue has room and
// tags it with its role in the frame (skipped, command, header name, colon,
// header value, line end, body, frame NUL). Each octet gives zero, one or two
// results; the closing result carries status, body length, header count and
// consumed octets, and the parser then starts over on the next frame. An octet
// is held in the input register, tagged by the parse engine as it is taken and
// written into a four-entry result queue, which offers it on the output. Input
// runs at one octet per cycle while at least two queue entries are free; the
// output side sends one result per cycle while the receiver is ready, so a run
// of octets yielding two results (CR LF pairs, released CRs) is paced by the
// output at one result per cycle.
// ----------------------------------------------------------------------------
module stomp_frame_parser #(
  parameter int MAX_HEADERS = sfp_pkg::MaxHeadersDefault,
  parameter int LENGTH_BITS = sfp_pkg::LengthBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sfp_stream_if.sink   in_i,
  sfp_stream_if.source out_o
);
  import sfp_pkg::*;

  logic      item_valid;
  in_item_t  item;
  logic      take;
  logic      space;
  res_pair_t push;

  sfp_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .valid_o (item_valid),
    .item_o  (item)
  );

  sfp_engine #(
    .MAX_HEADERS (MAX_HEADERS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .space_i      (space),
    .take_o       (take),
    .push_o       (push)
  );

  sfp_out_queue u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .out_o   (out_o)
  );

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream-level bench of the STOMP frame parser: random and directed octet
// streams go in, every tagged result is checked against a cycle-free model
// of the parser kept in the bench, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  import sfp_pkg::*;

  localparam int          WatchLimit = 2000;
  localparam int          DrainCycles = 16;
  localparam int          StallCycles = 300;
  localparam logic [4:0]  HdrLimit = 5'(MaxHeadersDefault);
  localparam logic [31:0] LenGuard = (SatOctets - 32'd9) / 32'd10;
  localparam logic [8*14-1:0] LenKey = "content-length";

  logic clk_i;
  logic rst_ni;

  sfp_stream_if #(.T(in_item_t))  in_if ();
  sfp_stream_if #(.T(out_item_t)) out_if ();

  stomp_frame_parser i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  in_item_t   octet_q[$];
  out_item_t  predicted_tags[$];
  logic [7:0] frame_bytes[$];

  logic in_taken;
  logic out_taken;
  logic hold_out;
  int   send_wait;
  int   send_calm;
  int   recv_wait;
  int   recv_calm;
  int   accepted_octets;
  int   stuck_cycles;
  int   mismatches;
  out_item_t head_tag;

  // parser model state
  phase_e      cur_phase;
  logic        held_cr;
  logic        line_content;
  logic        colon_seen;
  logic [4:0]  kept_hdrs;
  logic [3:0]  match_pos;
  logic        name_bad;
  logic        len_hdr_seen;
  logic [31:0] len_acc;
  logic        digits_bad;
  logic        len_line_active;
  logic        digit_seen;
  logic [31:0] body_cnt;
  logic [31:0] octet_cnt;
  out_item_t   run_tags [2];
  int          run_len;

  function automatic void clear_line();
    line_content    = 1'b0;
    colon_seen      = 1'b0;
    match_pos       = '0;
    name_bad        = 1'b0;
    len_line_active = 1'b0;
    digit_seen      = 1'b0;
    digits_bad      = 1'b0;
  endfunction

  function automatic void restart_frame();
    cur_phase    = PH_SKIP;
    held_cr      = 1'b0;
    kept_hdrs    = '0;
    len_hdr_seen = 1'b0;
    len_acc      = '0;
    body_cnt     = '0;
    octet_cnt    = '0;
    clear_line();
  endfunction

  function automatic void put_tag(input role_e role, input logic [7:0] value);
    out_item_t t;
    if (run_len < 2) begin
      t.byte_role       = role;
      t.byte_value      = value;
      t.header_slot     = (kept_hdrs < HdrLimit) ? kept_hdrs : HdrLimit;
      t.frame_done      = 1'b0;
      t.status          = ST_BUSY;
      t.body_length     = body_cnt;
      t.header_total    = kept_hdrs;
      t.consumed_octets = octet_cnt;
      t.last_of_run     = 1'b0;
      run_tags[run_len] = t;
      run_len++;
    end
  endfunction

  // one octet of a command or header line
  function automatic void line_octet(input logic [7:0] b);
    line_content = 1'b1;
    if (cur_phase == PH_CMD) begin
      put_tag(ROLE_CMD, b);
    end else if (!colon_seen && b == CharColon) begin
      colon_seen      = 1'b1;
      len_line_active = !name_bad && match_pos == KeyLen && kept_hdrs < HdrLimit &&
                        !len_hdr_seen;
      if (len_line_active) len_acc = '0;
      digits_bad = 1'b0;
      digit_seen = 1'b0;
      put_tag(ROLE_COLON, b);
    end else if (!colon_seen) begin
      if (!name_bad) begin
        if (match_pos < KeyLen && b == LenKey[8*(13 - int'(match_pos)) +: 8]) begin
          match_pos++;
        end else begin
          name_bad = 1'b1;
        end
      end
      put_tag(ROLE_HDR_NAME, b);
    end else begin
      if (len_line_active && !digits_bad) begin
        if (b >= CharZero && b <= CharNine) begin
          // conservative overflow test before the multiply
          if (len_acc > LenGuard) begin
            digits_bad = 1'b1;
          end else begin
            len_acc    = len_acc * 32'd10 + 32'(b - CharZero);
            digit_seen = 1'b1;
          end
        end else begin
          digits_bad = 1'b1;
        end
      end
      put_tag(ROLE_HDR_VALUE, b);
    end
  endfunction

  function automatic status_e end_of_line();
    status_e st;
    st = ST_BUSY;
    put_tag(ROLE_LINE_END, CharLf);
    if (cur_phase == PH_CMD) begin
      cur_phase = PH_HDR;
      clear_line();
    end else if (!line_content) begin
      cur_phase = len_hdr_seen ? PH_BODY_SIZED : PH_BODY_OPEN;
      body_cnt  = '0;
      clear_line();
    end else if (!colon_seen) begin
      st = ST_NO_COLON;
    end else if (len_line_active && (digits_bad || !digit_seen)) begin
      st = ST_BAD_LENGTH;
    end else begin
      if (len_line_active) len_hdr_seen = 1'b1;
      if (kept_hdrs < HdrLimit) kept_hdrs++;
      clear_line();
    end
    return st;
  endfunction

  task automatic tag_octet(input logic [7:0] b, input logic eob);
    status_e verdict;
    verdict = ST_BUSY;
    run_len = 0;
    if (octet_cnt != SatOctets) octet_cnt++;
    if (cur_phase == PH_SKIP) begin
      if (b == CharCr || b == CharLf) put_tag(ROLE_SKIP, b);
      else cur_phase = PH_CMD;
    end
    if (cur_phase == PH_CMD || cur_phase == PH_HDR) begin
      if (held_cr) begin
        held_cr = 1'b0;
        if (b == CharLf) begin
          put_tag(ROLE_LINE_END, CharCr);
          verdict = end_of_line();
        end else begin
          line_octet(CharCr);
          if (b == CharCr) held_cr = 1'b1;
          else line_octet(b);
        end
      end else if (b == CharLf) begin
        verdict = end_of_line();
      end else if (b == CharCr) begin
        held_cr = 1'b1;
      end else begin
        line_octet(b);
      end
    end else if (cur_phase == PH_BODY_SIZED) begin
      if (body_cnt < len_acc) begin
        body_cnt++;
        put_tag(ROLE_BODY, b);
      end else if (b == CharNul) begin
        put_tag(ROLE_NUL, b);
        verdict = ST_OK;
      end else begin
        put_tag(ROLE_SKIP, b);
        verdict = ST_NUL_MISPLACED;
      end
    end else if (cur_phase == PH_BODY_OPEN) begin
      if (b == CharNul) begin
        put_tag(ROLE_NUL, b);
        verdict = ST_OK;
      end else begin
        if (body_cnt != SatOctets) body_cnt++;
        put_tag(ROLE_BODY, b);
      end
    end

    if (verdict == ST_BUSY && eob) begin
      // a held cr goes out as plain content before the attempt is dropped
      if (held_cr) begin
        held_cr = 1'b0;
        put_tag(cur_phase == PH_CMD ? ROLE_CMD :
                (colon_seen ? ROLE_HDR_VALUE : ROLE_HDR_NAME), CharCr);
      end
      verdict = ST_INCOMPLETE;
    end

    if (run_len > 0) begin
      run_tags[run_len-1].last_of_run = 1'b1;
      if (verdict != ST_BUSY) begin
        run_tags[run_len-1].frame_done      = 1'b1;
        run_tags[run_len-1].status          = verdict;
        run_tags[run_len-1].body_length     = (verdict == ST_OK) ? body_cnt : '0;
        run_tags[run_len-1].header_total    = kept_hdrs;
        run_tags[run_len-1].consumed_octets = (verdict == ST_OK) ? octet_cnt : '0;
      end
    end
    for (int i = 0; i < run_len; i++) predicted_tags.push_back(run_tags[i]);
    if (verdict != ST_BUSY) restart_frame();
  endtask

  function automatic string fmt_tag(input out_item_t t);
    return $sformatf("role=%0d byte=%02h slot=%0d done=%0d status=%0d body=%0d hdrs=%0d %s%0d",
                     t.byte_role, t.byte_value, t.header_slot, t.frame_done, t.status,
                     t.body_length, t.header_total,
                     $sformatf("octets=%0d last=", t.consumed_octets), t.last_of_run);
  endfunction

  function automatic int draw_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    return $urandom_range(0, 1) ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic logic [7:0] pick_letter();
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  // any octet that keeps the current line open
  function automatic logic [7:0] pick_line_octet(input bit no_colon);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == CharLf || (no_colon && b == CharColon));
    return b;
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
  endfunction

  function automatic void add_eol();
    if ($urandom_range(0, 1)) frame_bytes.push_back(CharCr);
    frame_bytes.push_back(CharLf);
  endfunction

  // move the frame into the octet queue, end of buffer flagged at index cut
  function automatic void queue_frame(input int cut);
    in_item_t it;
    int       last;
    last = (cut >= 0) ? cut : frame_bytes.size() - 1;
    for (int i = 0; i <= last; i++) begin
      it.data_byte     = frame_bytes[i];
      it.end_of_buffer = (i == cut);
      octet_q.push_back(it);
    end
    frame_bytes.delete();
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // sender: one gap draw per accepted transaction
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) send_wait = draw_gap(send_calm);
      if (!in_if.valid || in_taken) begin
        if (send_wait > 0 || octet_q.size() == 0) begin
          if (send_wait > 0) send_wait--;
          in_if.valid <= 1'b0;
        end else begin
          in_if.payload <= octet_q.pop_front();
          in_if.valid   <= 1'b1;
        end
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) recv_wait = draw_gap(recv_calm);
      if (hold_out || recv_wait > 0) begin
        if (!hold_out) recv_wait--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // long output hold-off while input keeps coming, fills the result queue
  initial begin
    hold_out = 1'b0;
    wait (accepted_octets >= 150);
    hold_out = 1'b1;
    repeat (StallCycles) @(posedge clk_i);
    hold_out = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= in_if.valid && in_if.ready;
      out_taken <= out_if.valid && out_if.ready;
      if (in_if.valid && in_if.ready) begin
        tag_octet(in_if.payload.data_byte, in_if.payload.end_of_buffer);
        accepted_octets++;
      end
      if (out_if.valid && out_if.ready) begin
        if (predicted_tags.size() == 0) begin
          if (mismatches < 10) $display("unexpected result: %s", fmt_tag(out_if.payload));
          mismatches++;
        end else begin
          head_tag = predicted_tags.pop_front();
          if (out_if.payload !== head_tag) begin
            if (mismatches < 10) begin
              $display("result mismatch\n  expected %s\n  actual   %s",
                       fmt_tag(head_tag), fmt_tag(out_if.payload));
            end
            mismatches++;
          end
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= WatchLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int hdr_n;
    int len_at;
    int body_n;
    int cut;
    bit sized;
    bit stop;
    bit big_len;

    in_if.valid     = 1'b0;
    in_if.payload   = '0;
    out_if.ready    = 1'b0;
    send_wait       = 0;
    send_calm       = 0;
    recv_wait       = 0;
    recv_calm       = 0;
    accepted_octets = 0;
    stuck_cycles    = 0;
    mismatches      = 0;
    rst_ni          = 1'b0;
    restart_frame();

    // leading line ends, trimmed cr, sized body with extreme octets
    frame_bytes = '{CharCr, CharLf};
    add_text("S");
    frame_bytes.push_back(CharCr);
    frame_bytes.push_back(CharLf);
    add_text("content-length:1");
    frame_bytes.push_back(CharLf);
    frame_bytes.push_back(CharLf);
    frame_bytes.push_back(8'hFF);
    frame_bytes.push_back(CharNul);
    queue_frame(-1);
    // cr cr releases the first, end of buffer releases the second
    add_text("X");
    frame_bytes.push_back(CharCr);
    frame_bytes.push_back(CharCr);
    queue_frame(2);

    while (octet_q.size() < 440) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise, dropped by end of buffer
        repeat ($urandom_range(1, 10)) frame_bytes.push_back(8'($urandom_range(0, 255)));
        queue_frame(frame_bytes.size() - 1);
      end else begin
        stop    = 1'b0;
        big_len = 1'b0;
        repeat ($urandom_range(0, 2)) frame_bytes.push_back($urandom_range(0, 1) ? CharCr : CharLf);
        repeat ($urandom_range(1, 4)) begin
          frame_bytes.push_back($urandom_range(0, 7) == 0 ? pick_line_octet(0) : pick_letter());
        end
        add_eol();
        hdr_n  = ($urandom_range(0, 11) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 3);
        len_at = (hdr_n > 0 && $urandom_range(0, 1)) ? $urandom_range(0, hdr_n - 1) : -1;
        body_n = $urandom_range(0, 6);
        sized  = len_at >= 0 && len_at < MaxHeadersDefault;
        for (int i = 0; i < hdr_n && !stop; i++) begin
          if (i == len_at) begin
            add_text("content-length");
            frame_bytes.push_back(CharColon);
            case ($urandom_range(0, 9))
              0: stop = sized;
              1: begin
                add_text("1x");
                stop = sized;
              end
              2: begin
                add_text("4294967296");
                stop = sized;
              end
              3: begin
                // largest value the overflow test lets through
                add_text("4294967289");
                big_len = 1'b1;
              end
              default: begin
                if ($urandom_range(0, 3) == 0) add_text("00");
                add_text($sformatf("%0d", body_n));
              end
            endcase
          end else if ($urandom_range(0, 24) == 0) begin
            // header line without a colon
            repeat ($urandom_range(1, 3)) frame_bytes.push_back(pick_letter());
            stop = 1'b1;
          end else begin
            case ($urandom_range(0, 9))
              0: add_text("content-lengt");
              1: add_text("content-lengthx");
              2: add_text("Content-Length");
              3: add_text((len_at >= 0 && i > len_at) ? "content-length" : "c");
              default: begin
                repeat ($urandom_range(1, 3)) begin
                  frame_bytes.push_back($urandom_range(0, 5) == 0 ? pick_line_octet(1)
                                                                  : pick_letter());
                end
              end
            endcase
            frame_bytes.push_back(CharColon);
            repeat ($urandom_range(0, 4)) frame_bytes.push_back(pick_line_octet(0));
          end
          add_eol();
        end
        if (!stop) begin
          add_eol();
          if (big_len && sized) begin
            repeat ($urandom_range(0, 4)) frame_bytes.push_back(8'($urandom_range(0, 255)));
          end else if (sized) begin
            repeat (body_n) frame_bytes.push_back(8'($urandom_range(0, 255)));
            frame_bytes.push_back($urandom_range(0, 7) == 0 ? 8'($urandom_range(1, 255))
                                                            : CharNul);
          end else begin
            repeat (body_n) frame_bytes.push_back(8'($urandom_range(1, 255)));
            frame_bytes.push_back(CharNul);
          end
        end
        if (big_len && sized && !stop) cut = frame_bytes.size() - 1;
        else if ($urandom_range(0, 9) == 0) cut = $urandom_range(0, frame_bytes.size() - 1);
        else if ($urandom_range(0, 3) == 0) cut = frame_bytes.size() - 1;
        else cut = -1;
        queue_frame(cut);
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (octet_q.size() != 0 || in_if.valid) @(negedge clk_i);
    while (predicted_tags.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && predicted_tags.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
